@@ hw/rtl/cosine_topk_vector_search_macros.svh @@
// Assertion macros for the cosine top-K search block.
// Used by the top level only; no other dependencies.
`ifndef COSINE_TOPK_VECTOR_SEARCH_MACROS_SVH
`define COSINE_TOPK_VECTOR_SEARCH_MACROS_SVH
`ifndef SYNTH
`define CTS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CTS_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CTS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define CTS_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/cts_pkg.sv @@
// Shared types and constants for the cosine top-K search block.
// No dependencies.
package cts_pkg;
  localparam int unsigned MaxDims = 384;
  localparam int unsigned TopKMax = 16;
  localparam int unsigned TopKReset = 10;

  typedef enum logic [1:0] {
    CMD_QUERY = 2'd0,
    CMD_CAND  = 2'd1,
    CMD_EMIT  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_QUERY = 2'd1,
    ST_NO_CAND  = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic signed [15:0] element;
    logic [31:0] item_id;
    logic        last_element;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  rank;
    logic [31:0] item_id_res;
    logic signed [15:0] score;
    logic [31:0] scanned;
    logic        last;
  } out_beat_t;

  // Score unit handshake.
  typedef struct packed {
    logic        start;
    logic signed [40:0] dot;
    logic [40:0] na;
    logic [40:0] nb;
  } score_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic signed [15:0] score;
  } score_rsp_t;
endpackage

@@ hw/rtl/cts_if.sv @@
// Valid/ready stream interface carrying one beat of a given payload type.
// Depends on cts_pkg for the payload types.
interface cts_if #(
  parameter type T = cts_pkg::in_beat_t
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/cts_score.sv @@
// Sequential score unit: 82-bit product, bit-serial square root, restoring divide.
// Depends on cts_pkg.
module cts_score (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cts_pkg::score_req_t req_i,
  output cts_pkg::score_rsp_t rsp_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic [40:0] na_q, na_d, nb_q, nb_d;
  logic [81:0] prod_q, prod_d;
  // sqrt: remainder / root with digit-by-digit method
  logic [83:0] rem_q, rem_d;
  logic [41:0] root_q, root_d;
  logic [55:0] num_q, num_d;
  logic [56:0] drem_q, drem_d;
  logic [15:0] score_q, score_d;
  logic [20:0] pa_q, pa_d;   // 21-bit chunk of na for partial products
  logic [81:0] part;
  logic [83:0] trial;
  logic [56:0] dsh;
  logic [41:0] qbits_q, qbits_d;

  always_comb begin
    part = 82'(pa_q) * 82'(nb_q);
    trial = {rem_q[81:0], prod_q[81:80]} - {40'd0, root_q, 2'b01};
    dsh = {drem_q[55:0], num_q[55]};
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    na_d = na_q;
    nb_d = nb_q;
    prod_d = prod_q;
    rem_d = rem_q;
    root_d = root_q;
    num_d = num_q;
    drem_d = drem_q;
    score_d = score_q;
    pa_d = pa_q;
    qbits_d = qbits_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          neg_d = req_i.dot[40];
          num_d = {(req_i.dot[40] ? 41'(-req_i.dot) : 41'(req_i.dot)), 15'd0};
          na_d = req_i.na;
          nb_d = req_i.nb;
          pa_d = req_i.na[20:0];
          prod_d = '0;
          cnt_d = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // two 21x41 partial products
        if (cnt_q == 6'd0) begin
          prod_d = part;
          pa_d = {1'b0, na_q[40:21]};
          cnt_d = 6'd1;
        end else begin
          prod_d = prod_q + {part[60:0], 21'd0};
          rem_d = '0;
          root_d = '0;
          cnt_d = 6'd0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!trial[83]) begin
          rem_d = trial;
          root_d = {root_q[40:0], 1'b1};
        end else begin
          rem_d = {rem_q[81:0], prod_q[81:80]};
          root_d = {root_q[40:0], 1'b0};
        end
        prod_d = {prod_q[79:0], 2'b00};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd40) begin
          cnt_d = '0;
          drem_d = '0;
          qbits_d = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (root_q == '0) begin
          score_d = '0;
          state_d = S_DONE;
        end else begin
          if (dsh >= {15'd0, root_q}) begin
            drem_d = dsh - {15'd0, root_q};
            qbits_d = {qbits_q[40:0], 1'b1};
          end else begin
            drem_d = dsh;
            qbits_d = {qbits_q[40:0], 1'b0};
          end
          num_d = {num_q[54:0], 1'b0};
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == 6'd55) state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (root_q != '0) begin
          score_d = (qbits_q > 42'd32767) ? 16'sd32767 : qbits_q[15:0];
          if (neg_q) score_d = -score_d;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // 56 divide steps exceed the 6-bit counter check only at 55: fits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    na_q <= na_d;
    nb_q <= nb_d;
    prod_q <= prod_d;
    rem_q <= rem_d;
    root_q <= root_d;
    num_q <= num_d;
    drem_q <= drem_d;
    score_q <= score_d;
    pa_q <= pa_d;
    qbits_q <= qbits_d;
  end

  assign rsp_o.busy = (state_q != S_IDLE);
  assign rsp_o.done = (state_q == S_DONE);
  assign rsp_o.score = score_d;
endmodule

@@ hw/rtl/cosine_topk_vector_search.sv @@
// Top level of the cosine top-K search: query memory, accumulators, ranking memory.
// Depends on cts_pkg, cts_if, cts_score and the assertion macro header.
//
//  channel   | dir | handshake     | beat
//  in_if     | in  | valid/ready   | command, element, item_id, last_element
//  out_if    | out | valid/ready   | status, rank, item_id_res, score, scanned, last
//  apb       | in  | psel/penable  | top_k at address 0
//
// A query, emit or clear beat is handled as it is taken. A candidate element beat takes
// two steps: the cycle it is taken reads the query memory, the next one accumulates.
// A candidate's last beat then runs the score unit (two multiply steps, 41 root steps,
// 56 divide steps and one to finish; one divide step when the root is zero), and an
// insertion that reads, then compares, one ranking entry at a time, up to TOP_K_MAX
// entries. An emit reads each result beat in F_EMRD and sends it in F_EMIT while the
// sink is ready. Reset is asynchronous and active low; the memories need no clearing.
// A stalled output holds its beat in the output register and no new input is taken.
`include "cosine_topk_vector_search_macros.svh"
module cosine_topk_vector_search #(
  parameter int unsigned QUERY_DEPTH = cts_pkg::MaxDims,
  parameter int unsigned TOP_K_MAX   = cts_pkg::TopKMax
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cts_if.sink         in_if,
  cts_if.source       out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned QAW = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
  localparam int unsigned LW  = $clog2(QUERY_DEPTH + 2);
  localparam int unsigned KAW = (TOP_K_MAX > 1) ? $clog2(TOP_K_MAX) : 1;
  localparam int unsigned KCW = $clog2(TOP_K_MAX + 1);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_ACC  = 3'd1;
  localparam logic [2:0] F_SCORE = 3'd2;
  localparam logic [2:0] F_INS  = 3'd3;
  localparam logic [2:0] F_EMIT = 3'd4;
  localparam logic [2:0] F_EMRD = 3'd5;

  // Configuration: one register at address 0.
  logic [4:0] top_k_q;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {27'd0, top_k_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) top_k_q <= 5'(cts_pkg::TopKReset);
    else if (psel && penable && pwrite && paddr == 2'd0) top_k_q <= pwdata[4:0];
  end

  // Memories.
  logic signed [15:0] qmem [QUERY_DEPTH];
  logic signed [15:0] qrd_q;
  logic [15:0] bsc [TOP_K_MAX];
  logic [31:0] bid [TOP_K_MAX];
  logic [15:0] bsc_rd_q;
  logic [31:0] bid_rd_q;

  logic [2:0]  fsm_q, fsm_d;
  logic [LW-1:0] qlen_q, cidx_q;
  logic [40:0] qnorm_q, cnorm_q;
  logic signed [40:0] dot_q;
  logic        qopen_q;
  logic [KCW-1:0] bcnt_q;
  logic [31:0] scanned_q;
  cts_pkg::in_beat_t beat_q;
  logic [KCW-1:0] ptr_q;      // insert scan / emit index
  logic [KCW-1:0] show_q;
  logic signed [15:0] ins_sc_q;
  logic [31:0] ins_id_q;
  logic        ins_found_q;
  logic        ovalid_q;
  cts_pkg::out_beat_t obeat_q;

  cts_pkg::score_req_t sreq;
  cts_pkg::score_rsp_t srsp;
  cts_score u_score (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(sreq), .rsp_o(srsp));

  logic loaded;
  logic take;
  logic out_free;
  logic emit_err;
  logic out_load;
  logic signed [31:0] prod_e;
  logic [31:0] sq_e;
  logic [KCW-1:0] kclamp;
  logic [LW-1:0] qlen_eff;
  logic [LW-1:0] cidx_next;
  assign loaded = qopen_q && (qlen_q != '0);
  assign out_free = !ovalid_q || out_if.ready;
  assign in_if.ready = (fsm_q == F_IDLE) && out_free;
  assign take = in_if.valid && in_if.ready;
  // An emit that finds no query or no candidate answers with a single error beat.
  assign emit_err = take && (in_if.data.command == cts_pkg::CMD_EMIT)
                    && (!loaded || scanned_q == '0 || bcnt_q == '0);
  assign out_load = emit_err || (fsm_q == F_EMIT && out_free);
  assign prod_e = 32'(qrd_q) * 32'(beat_q.element);
  assign sq_e = 32'($signed(beat_q.element) * $signed(beat_q.element));
  // A query beat arriving while the query is open starts a new one at index 0.
  assign qlen_eff = qopen_q ? '0 : qlen_q;
  // The candidate index saturates one above the memory depth.
  assign cidx_next = (cidx_q <= LW'(QUERY_DEPTH)) ? cidx_q + LW'(1) : cidx_q;
  always_comb begin
    if (top_k_q == 5'd0) kclamp = KCW'(1);
    else if (32'(top_k_q) > TOP_K_MAX) kclamp = KCW'(TOP_K_MAX);
    else kclamp = KCW'(top_k_q);
  end

  // Query memory port: write on query beat, read at the candidate index every cycle.
  always_ff @(posedge clk_i) begin
    if (take && in_if.data.command == cts_pkg::CMD_QUERY) begin
      if (qlen_eff < LW'(QUERY_DEPTH)) qmem[qlen_eff[QAW-1:0]] <= in_if.data.element;
    end
    if (cidx_q < LW'(QUERY_DEPTH)) qrd_q <= qmem[cidx_q[QAW-1:0]];
    else qrd_q <= '0;
  end

  // Ranking memory: one write, one read per cycle.
  logic          rk_we;
  logic [KAW-1:0] rk_wa, rk_ra;
  logic [15:0]   rk_wsc;
  logic [31:0]   rk_wid;
  always_ff @(posedge clk_i) begin
    if (rk_we) begin
      bsc[rk_wa] <= rk_wsc;
      bid[rk_wa] <= rk_wid;
    end
    bsc_rd_q <= bsc[rk_ra];
    bid_rd_q <= bid[rk_ra];
  end

  // Insertion walks down from one past the last entry: read entry ptr-1, compare,
  // shift or place. When the list is full the walk starts past its end, so a score
  // no better than the lowest entry is dropped. Reads are registered, so ptr advances
  // one entry per read phase and compare phase, with ins_found_q as the phase bit.
  always_comb begin
    fsm_d = fsm_q;
    sreq = '0;
    sreq.dot = dot_q;
    sreq.na = qnorm_q;
    sreq.nb = cnorm_q;
    rk_we = 1'b0;
    rk_wa = '0;
    rk_ra = '0;
    rk_wsc = ins_sc_q;
    rk_wid = ins_id_q;
    if (ptr_q != '0) rk_ra = KAW'(ptr_q - KCW'(1));
    if (fsm_q == F_EMIT || fsm_q == F_EMRD) rk_ra = ptr_q[KAW-1:0];
    unique case (fsm_q)
      F_IDLE: if (take && (in_if.data.command == cts_pkg::CMD_CAND) && loaded) fsm_d = F_ACC;
              else if (take && in_if.data.command == cts_pkg::CMD_EMIT && !emit_err)
                fsm_d = F_EMRD;
      F_ACC: begin
        if (beat_q.last_element && (cidx_next == qlen_q)) begin
          sreq.start = 1'b1;
          sreq.dot = dot_q + ((cidx_q < qlen_q) ? 41'(prod_e) : 41'sd0);
          sreq.nb = cnorm_q + ((cidx_q < qlen_q) ? 41'(sq_e) : 41'd0);
          fsm_d = F_SCORE;
        end else fsm_d = F_IDLE;
      end
      F_SCORE: if (srsp.done) fsm_d = F_INS;
      F_INS: begin
        if (ins_found_q) begin
          // phase 2: entry ptr-1 read data available
          if (ptr_q != '0 && $signed(bsc_rd_q) < ins_sc_q) begin
            if (ptr_q < KCW'(TOP_K_MAX)) begin
              rk_we = 1'b1;
              rk_wa = ptr_q[KAW-1:0];
              rk_wsc = bsc_rd_q;
              rk_wid = bid_rd_q;
            end
          end else begin
            if (ptr_q < KCW'(TOP_K_MAX)) begin
              rk_we = 1'b1;
              rk_wa = ptr_q[KAW-1:0];
            end
            fsm_d = F_IDLE;
          end
        end else if (ptr_q == '0) begin
          rk_we = 1'b1;
          rk_wa = '0;
          fsm_d = F_IDLE;
        end
      end
      F_EMRD: fsm_d = F_EMIT;
      F_EMIT: if (out_free && ptr_q + KCW'(1) == show_q) fsm_d = F_IDLE;
              else if (out_free) fsm_d = F_EMRD;
      default: fsm_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= F_IDLE;
      qlen_q <= '0;
      qnorm_q <= '0;
      qopen_q <= 1'b1;
      cidx_q <= '0;
      dot_q <= '0;
      cnorm_q <= '0;
      bcnt_q <= '0;
      scanned_q <= '0;
      ovalid_q <= 1'b0;
      ptr_q <= '0;
      show_q <= '0;
      ins_found_q <= 1'b0;
    end else begin
      fsm_q <= fsm_d;
      if (out_load) ovalid_q <= 1'b1;
      else if (out_if.ready) ovalid_q <= 1'b0;
      if (take) begin
        unique case (in_if.data.command)
          cts_pkg::CMD_QUERY: begin
            if (qopen_q) begin
              cidx_q <= '0; dot_q <= '0; cnorm_q <= '0;
              bcnt_q <= '0; scanned_q <= '0;
            end
            if (qlen_eff < LW'(QUERY_DEPTH)) begin
              qlen_q <= qlen_eff + LW'(1);
              qnorm_q <= (qopen_q ? 41'd0 : qnorm_q)
                + 41'(32'($signed(in_if.data.element) * $signed(in_if.data.element)));
            end else begin
              qlen_q <= qlen_eff;
              if (qopen_q) qnorm_q <= '0;
            end
            qopen_q <= in_if.data.last_element;
          end
          cts_pkg::CMD_CAND: ;
          cts_pkg::CMD_EMIT: begin
            if (!emit_err) begin
              ptr_q <= '0;
              show_q <= (bcnt_q < kclamp) ? bcnt_q : kclamp;
            end
          end
          cts_pkg::CMD_CLEAR: begin
            qlen_q <= '0; qnorm_q <= '0; qopen_q <= 1'b1;
            cidx_q <= '0; dot_q <= '0; cnorm_q <= '0;
            bcnt_q <= '0; scanned_q <= '0;
          end
          default: ;
        endcase
      end
      if (fsm_q == F_ACC) begin
        if (beat_q.last_element) begin
          cidx_q <= '0; dot_q <= '0; cnorm_q <= '0;
          if (cidx_next == qlen_q) begin
            if (scanned_q != '1) scanned_q <= scanned_q + 32'd1;
          end
        end else begin
          cidx_q <= cidx_next;
          if (cidx_q < qlen_q) begin
            dot_q <= dot_q + 41'(prod_e);
            cnorm_q <= cnorm_q + 41'(sq_e);
          end
        end
      end
      if (fsm_q == F_SCORE && srsp.done) begin
        ptr_q <= bcnt_q;
        ins_found_q <= 1'b0;
        if (bcnt_q < KCW'(TOP_K_MAX)) bcnt_q <= bcnt_q + KCW'(1);
      end
      if (fsm_q == F_INS) begin
        if (!ins_found_q) begin
          if (ptr_q != '0) ins_found_q <= 1'b1;
        end else begin
          ins_found_q <= 1'b0;
          if (ptr_q != '0 && $signed(bsc_rd_q) < ins_sc_q) ptr_q <= ptr_q - KCW'(1);
        end
      end
      if (fsm_q == F_EMIT && out_free) ptr_q <= ptr_q + KCW'(1);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (take) beat_q <= in_if.data;
    if (fsm_q == F_ACC && beat_q.last_element) ins_id_q <= beat_q.item_id;
    if (fsm_q == F_SCORE && srsp.done) ins_sc_q <= srsp.score;
    if (out_load) begin
      if (emit_err) begin
        obeat_q <= '{status: loaded ? cts_pkg::ST_NO_CAND : cts_pkg::ST_NO_QUERY,
                     rank: '0, item_id_res: '0, score: '0,
                     scanned: scanned_q, last: 1'b1};
      end else begin
        obeat_q <= '{status: cts_pkg::ST_OK, rank: 4'(ptr_q), item_id_res: bid_rd_q,
                     score: bsc_rd_q, scanned: scanned_q,
                     last: (ptr_q + KCW'(1) == show_q)};
      end
    end
  end

  assign out_if.valid = ovalid_q;
  assign out_if.data = obeat_q;

  `CTS_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, fsm_q != F_IDLE, !in_if.ready)
  `CTS_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, bcnt_q <= KCW'(TOP_K_MAX))
  `CTS_ASSERT_NXT(a_score_start, clk_i, rst_ni, sreq.start, srsp.busy)
endmodule
